// ===== design/sli_pkg.sv =====
// Shared types and constants for the sorted list block.
`default_nettype none

package sli_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned KEY_W    = 8;

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef struct packed {
    opcode_e           opcode;
    logic [KEY_W-1:0]  key;
  } sli_cmd_t;

  typedef struct packed {
    status_e     status;
    logic [3:0]  position;
    logic [4:0]  count;
  } sli_res_t;

  // Broadcast from the top level to every cell in the row.
  typedef struct packed {
    logic              ins_en;
    logic              del_en;
    logic [KEY_W-1:0]  key;
  } sli_ctrl_t;

endpackage : sli_pkg

`default_nettype wire

// ===== design/sli_cell.sv =====
// One list entry: compares against the broadcast key and shifts with its neighbours.
`default_nettype none

module sli_cell
  import sli_pkg::*;
(
  input  wire logic             clk_i,
  input  wire sli_ctrl_t        ctrl_i,
  input  wire logic             valid_i,      // entry lies below the fill count
  input  wire logic             left_lt_i,    // left neighbour holds a smaller key (1 at head)
  input  wire logic [KEY_W-1:0] left_entry_i,
  input  wire logic [KEY_W-1:0] right_entry_i,
  output logic                  lt_o,
  output logic                  eq_o,
  output logic [KEY_W-1:0]      entry_o
);

  logic [KEY_W-1:0] entry_q;
  logic [KEY_W-1:0] entry_d;

  assign lt_o    = valid_i && (entry_q < ctrl_i.key);
  assign eq_o    = valid_i && (entry_q == ctrl_i.key);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins_en && !lt_o) begin
      // first non-smaller cell takes the key, the rest move up a place
      entry_d = left_lt_i ? ctrl_i.key : left_entry_i;
    end else if (ctrl_i.del_en && !lt_o) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule : sli_cell

`default_nettype wire

// ===== design/sorted_list_insert_delete.sv =====
// Top level of the sorted list: a row of entry cells, the fill count and the result register.
//
// Keeps up to CAPACITY byte keys in ascending order. A transaction is taken
// on any edge with start high and busy low; busy is never raised, so one
// transaction is taken every cycle. Every cell compares its key against the
// command key in the same cycle and moves by at most one place, so the whole
// update completes in the cycle of acceptance and the next transaction sees
// the new list. The result appears on res_o in the cycle after acceptance, with
// res_valid_o high for exactly that cycle; the receiver cannot stall it, so
// it must be captured then. Insert into a full list is dropped with status
// full; delete of an absent key leaves the list alone with status not found.
// Equal keys on insert go in front of existing equal entries.
`default_nettype none

module sorted_list_insert_delete
  import sli_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output logic          busy,
  input  wire sli_cmd_t cmd_i,
  output logic          res_valid_o,
  output sli_res_t      res_o
);

  logic [CNT_W-1:0] count_q, count_d;
  logic             res_valid_q;
  sli_res_t         res_q, res_d;

  sli_ctrl_t        ctrl;
  logic [CAPACITY-1:0] lt, eq, valid;
  logic [KEY_W-1:0] entry [CAPACITY];

  logic             is_insert;
  logic             full;
  logic             found;
  logic [CNT_W-1:0] pos_cnt;
  logic [31:0]      pos_ext;
  logic [31:0]      cnt_ext;

  // every operation completes in its cycle of acceptance, so busy is never raised
  assign busy = 1'b0;

  assign is_insert = (cmd_i.opcode == OP_INSERT);
  assign full      = (count_q == CNT_W'(CAPACITY));
  assign found     = |eq;
  // lt is a run of ones from the head, so its length is both the
  // insertion point and the index of the first equal key
  assign pos_cnt   = CNT_W'($countones(lt));

  assign ctrl.key    = cmd_i.key;
  assign ctrl.ins_en = start && is_insert && !full;
  assign ctrl.del_en = start && !is_insert && found;

  // ---- row of cells -------------------------------------------------------
  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    logic             left_lt;
    logic [KEY_W-1:0] left_entry;
    logic [KEY_W-1:0] right_entry;

    assign valid[j] = (count_q > CNT_W'(j));

    if (j == 0) begin : g_head
      assign left_lt    = 1'b1;
      assign left_entry = '0;
    end else begin : g_body
      assign left_lt    = lt[j-1];
      assign left_entry = entry[j-1];
    end

    if (j == CAPACITY - 1) begin : g_tail
      assign right_entry = '0;
    end else begin : g_mid
      assign right_entry = entry[j+1];
    end

    sli_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .valid_i      (valid[j]),
      .left_lt_i    (left_lt),
      .left_entry_i (left_entry),
      .right_entry_i(right_entry),
      .lt_o         (lt[j]),
      .eq_o         (eq[j]),
      .entry_o      (entry[j])
    );
  end

  // ---- count and result ---------------------------------------------------
  always_comb begin
    count_d = count_q;
    if (ctrl.ins_en) begin
      count_d = count_q + CNT_W'(1);
    end else if (ctrl.del_en) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  assign pos_ext = 32'(pos_cnt);
  assign cnt_ext = 32'(count_d);

  always_comb begin
    res_d.count    = cnt_ext[4:0];
    res_d.position = pos_ext[3:0];
    res_d.status   = ST_DONE;
    if (is_insert && full) begin
      res_d.status   = ST_FULL;
      res_d.position = '0;
    end else if (!is_insert && !found) begin
      res_d.status   = ST_NOT_FOUND;
      res_d.position = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      res_valid_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // ---- assertions ---------------------------------------------------------
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  a_sorted_prefix : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lt & (lt + CAPACITY'(1))) == '0)
    else $error("smaller-key flags not a prefix: list out of order");

  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(start))
    else $error("result without a preceding transaction");

  a_delete_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !is_insert && found) |=> (count_q == $past(count_q) - CNT_W'(1)))
    else $error("successful delete did not drop the count");

  a_full_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && is_insert && full) |=> $stable(count_q))
    else $error("insert into full list changed the count");

endmodule : sorted_list_insert_delete

`default_nettype wire

// ===== bench/sorted_list_insert_delete_tb.sv =====
// Self-checking testbench for the sorted list insert/delete block.
module sorted_list_insert_delete_tb;
  import sli_pkg::*;

  // Generous: ~425 transactions with short gaps and a few drains stay well
  // within this limit.
  localparam int unsigned RUN_LIMIT  = 20000;
  localparam int unsigned RAND_ITEMS = 400;
  localparam int unsigned PHASE_LEN  = 50;
  localparam int unsigned MAX_SHOWN  = 10;

  logic     clk_i  = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start  = 1'b0;
  logic     busy;
  sli_cmd_t cmd    = '0;
  logic     res_valid;
  sli_res_t res;

  // A directed row may carry a hand-worked result; it travels alongside the
  // command so the monitor picks it up at the same accepting edge.
  logic     row_typed = 1'b0;
  sli_res_t row_res   = '0;

  typedef struct {
    sli_cmd_t cmd;
    bit       typed;
    sli_res_t res;
  } stim_row_t;

  stim_row_t  dir_rows[$];
  sli_res_t   outcome_q[$];   // results owed by the block, oldest first
  logic [7:0] shadow_keys[CAPACITY];
  int         shadow_len = 0;
  int         fault_cnt  = 0;
  int unsigned cycle_cnt = 0;

  sorted_list_insert_delete dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .cmd_i      (cmd),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the list: applies one operation and returns the result it owes.
  // Insert goes in front of equal entries; delete takes the first match.
  function automatic sli_res_t apply_list_op(input sli_cmd_t c);
    sli_res_t r;
    int       pos;
    r   = '{status: ST_DONE, position: 4'd0, count: 5'd0};
    pos = 0;
    if (c.opcode == OP_INSERT) begin
      if (shadow_len >= CAPACITY) begin
        r.status = ST_FULL;
        r.count  = 5'(shadow_len);
        return r;
      end
      while (pos < shadow_len && shadow_keys[pos] < c.key) pos++;
      for (int j = shadow_len; j > pos; j--) shadow_keys[j] = shadow_keys[j-1];
      shadow_keys[pos] = c.key;
      shadow_len++;
    end else begin
      while (pos < shadow_len && shadow_keys[pos] != c.key) pos++;
      if (pos >= shadow_len) begin
        r.status = ST_NOT_FOUND;
        r.count  = 5'(shadow_len);
        return r;
      end
      for (int j = pos; j + 1 < shadow_len; j++) shadow_keys[j] = shadow_keys[j+1];
      shadow_len--;
    end
    r.position = 4'(pos);
    r.count    = 5'(shadow_len);
    return r;
  endfunction

  task automatic note_fault(input string what, input sli_res_t want, input sli_res_t got);
    fault_cnt++;
    if (fault_cnt <= MAX_SHOWN)
      $display("%0t: %s: expected status %0d pos %0d count %0d, %s %0d pos %0d count %0d",
               $realtime, what, want.status, want.position, want.count,
               "got status", got.status, got.position, got.count);
  endtask

  // Monitor: everything is sampled at the rising edge, before the block's
  // own updates land. A result answers the transaction of the previous edge,
  // so it is checked before the new transaction is predicted.
  always @(posedge clk_i) begin
    sli_res_t want;
    if (rst_ni) begin
      if (res_valid === 1'b1) begin
        if (outcome_q.size() == 0) begin
          note_fault("result with nothing outstanding", '0, res);
        end else begin
          want = outcome_q.pop_front();
          if (res.status !== want.status || res.position !== want.position ||
              res.count !== want.count)
            note_fault("result mismatch", want, res);
        end
      end
      if (start && busy === 1'b0) begin
        want = apply_list_op(cmd);
        outcome_q.push_back(row_typed ? row_res : want);
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > RUN_LIMIT) begin
      $display("sorted_list_insert_delete_tb failed");
      $finish;
    end
  end

  function automatic void add_row(input opcode_e op, input logic [7:0] k, input bit typed,
                                  input status_e st = ST_DONE, input int pos = 0,
                                  input int cnt = 0);
    stim_row_t row;
    row.cmd   = '{opcode: op, key: k};
    row.typed = typed;
    row.res   = '{status: st, position: 4'(pos), count: 5'(cnt)};
    dir_rows.push_back(row);
  endfunction

  // Present one transaction and hold it until the block takes it. Returns
  // on the accepting edge; start stays high unless the caller idles.
  task automatic issue_cmd(input sli_cmd_t c, input bit typed, input sli_res_t r);
    cmd       <= c;
    row_typed <= typed;
    row_res   <= r;
    start     <= 1'b1;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
  endtask

  // Random gap before the next transaction, about a third of the time.
  task automatic maybe_idle(input bit allowed);
    if (allowed && $urandom_range(0, 99) < 32) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  // Hold off until every owed result has come back. Always waits on a clock
  // edge first, so start is never lowered and raised in the same step.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (outcome_q.size() != 0) @(posedge clk_i);
  endtask

  // Insert bias per phase of the random run: fill, churn near full, drain,
  // refill, and so on, so both ends of the list are hit repeatedly.
  int ins_bias[8] = '{85, 55, 10, 90, 50, 15, 80, 35};

  initial begin
    sli_cmd_t c;
    int       phase;
    bit       quiet;

    // Opening rows: empty list, extremes, duplicates, not found, full.
    add_row(OP_DELETE, 8'h00, 1'b1, ST_NOT_FOUND, 0, 0);   // delete from empty
    add_row(OP_INSERT, 8'h80, 1'b1, ST_DONE, 0, 1);
    add_row(OP_INSERT, 8'hFF, 1'b1, ST_DONE, 1, 2);
    add_row(OP_INSERT, 8'h00, 1'b1, ST_DONE, 0, 3);
    add_row(OP_INSERT, 8'h80, 1'b1, ST_DONE, 1, 4);        // lands before its twin
    add_row(OP_DELETE, 8'h55, 1'b1, ST_NOT_FOUND, 0, 4);
    add_row(OP_DELETE, 8'hFF, 1'b1, ST_DONE, 3, 3);        // tail entry
    add_row(OP_INSERT, 8'h7F, 1'b0);
    add_row(OP_INSERT, 8'h01, 1'b0);
    add_row(OP_INSERT, 8'hFE, 1'b0);
    add_row(OP_INSERT, 8'h40, 1'b0);
    add_row(OP_INSERT, 8'hC3, 1'b0);
    add_row(OP_INSERT, 8'h3C, 1'b0);
    add_row(OP_INSERT, 8'h80, 1'b0);
    add_row(OP_INSERT, 8'hAA, 1'b0);
    add_row(OP_INSERT, 8'h55, 1'b0);
    add_row(OP_INSERT, 8'h10, 1'b0);
    add_row(OP_INSERT, 8'hEF, 1'b0);
    add_row(OP_INSERT, 8'h00, 1'b0);
    add_row(OP_INSERT, 8'h9A, 1'b0);                       // list now full
    add_row(OP_INSERT, 8'h42, 1'b1, ST_FULL, 0, 16);       // dropped
    add_row(OP_DELETE, 8'h80, 1'b0);
    add_row(OP_INSERT, 8'h55, 1'b0);                       // back to full
    add_row(OP_DELETE, 8'h00, 1'b1, ST_DONE, 0, 15);       // first of two zeros

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      maybe_idle(1'b1);
      issue_cmd(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].res);
    end

    // Sender pauses until the block has answered everything.
    drain_results();

    for (int n = 0; n < RAND_ITEMS; n++) begin
      phase = n / PHASE_LEN;
      if (n % PHASE_LEN == 0 && n != 0 && $urandom_range(0, 1) == 1)
        drain_results();
      // Phases three and four draw no random gaps; only a drain at a phase boundary can pause them.
      quiet = (phase == 3 || phase == 4);
      maybe_idle(!quiet);
      if ($urandom_range(0, 99) < ins_bias[phase % 8]) begin
        c.opcode = OP_INSERT;
        // Narrow key bands now and then, to pile up duplicates.
        case ($urandom_range(0, 3))
          0:       c.key = 8'($urandom_range(0, 7));
          1:       c.key = 8'($urandom_range(248, 255));
          default: c.key = 8'($urandom_range(0, 255));
        endcase
      end else begin
        c.opcode = OP_DELETE;
        // Mostly hit a stored key; the rest are likely misses.
        if (shadow_len > 0 && $urandom_range(0, 99) < 70)
          c.key = shadow_keys[$urandom_range(0, shadow_len - 1)];
        else
          c.key = 8'($urandom_range(0, 255));
      end
      issue_cmd(c, 1'b0, '0);
    end

    drain_results();
    repeat (4) @(posedge clk_i);

    fault_cnt += outcome_q.size();
    if (fault_cnt == 0)
      $display("sorted_list_insert_delete_tb passed");
    else
      $display("sorted_list_insert_delete_tb failed");
    $finish;
  end

endmodule
